### rtl/mi3_pkg.sv
// shared widths, types and cofactor index tables for the 3x3 inverse
package mi3_pkg;

  localparam int ELEM_W  = 32;
  localparam int PROD_W  = 64;
  localparam int COF_W   = 64;
  localparam int DPP_W   = 96;
  localparam int DET_W   = 98;
  localparam int DMAG_W  = 97;
  localparam int QUO_W   = 32;
  localparam int EPS_W   = 31;
  localparam int N_ELEM  = 9;
  localparam int DIV_LAT = QUO_W + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic [3:0]               idx_t;

  localparam logic [QUO_W-1:0] QMAX = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] QMIN = 32'h8000_0000;

  // adjugate entry k = e[A]*e[B] - e[C]*e[D], k in row-major order
  localparam idx_t COF_A [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_B [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_C [N_ELEM] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t COF_D [N_ELEM] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd7, 4'd1};

endpackage

### rtl/mi3_div.sv
// pipelined restoring divider lane, one quotient bit per stage, saturated result
module mi3_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic [mi3_pkg::COF_W-1:0]        num_mag,
  input  logic                             num_neg,
  input  logic [mi3_pkg::DMAG_W-1:0]       den,
  output logic [mi3_pkg::QUO_W-1:0]        quo
);

  localparam int QW = mi3_pkg::QUO_W;
  localparam int DW = mi3_pkg::DMAG_W;
  localparam int NW = mi3_pkg::COF_W + 2 * FRAC_BITS;
  localparam int HW = NW - QW;
  localparam int CW = ((HW > DW) ? HW : DW) + 1;

  logic [NW-1:0] n_full;
  logic [CW-1:0] hi_c;
  logic          ovf_c;

  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [DW-1:0] dd   [QW+1];
  logic          ng   [QW+1];
  logic          ov   [QW+1];

  // scale numerator and catch quotients of 2^32 or more up front
  always_comb begin
    n_full = NW'(num_mag) << (2 * FRAC_BITS);
    hi_c   = CW'(n_full[NW-1:QW]);
    ovf_c  = hi_c >= CW'(den);
  end

  // entry stage
  always_ff @(posedge clk) begin
    rem[0] <= hi_c[DW-1:0];
    low[0] <= n_full[QW-1:0];
    q[0]   <= '0;
    dd[0]  <= den;
    ng[0]  <= num_neg;
    ov[0]  <= ovf_c;
  end

  // one shift, compare and subtract per stage
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      t    = {rem[i], low[i][QW-1]};
      ge   = t >= {1'b0, dd[i]};
      diff = t - {1'b0, dd[i]};
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
      low[i+1] <= low[i] << 1;
      q[i+1]   <= {q[i][QW-2:0], ge};
      dd[i+1]  <= dd[i];
      ng[i+1]  <= ng[i];
      ov[i+1]  <= ov[i];
    end
  end

  // sign and saturate
  always_comb begin
    if (ng[QW]) begin
      if (ov[QW] || (q[QW] > mi3_pkg::QMIN)) begin
        quo = mi3_pkg::QMIN;
      end else begin
        quo = '0 - q[QW];
      end
    end else begin
      if (ov[QW] || q[QW][QW-1]) begin
        quo = mi3_pkg::QMAX;
      end else begin
        quo = q[QW];
      end
    end
  end

endmodule

### rtl/matrix3x3_inverse.sv
// 3x3 fixed-point matrix inverse by adjugate: top level
// done is the end of the valid shift register that runs beside the datapath registers
// throughput: one matrix per cycle, busy is always low
// the divider lanes (an entry stage, then 32 restoring stages, one quotient bit per stage) set the depth
// reset clears the valid pipeline and done, and sets det_epsilon to 1
// results carry no backpressure: done marks each word for one cycle
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_we,
  input  logic [mi3_pkg::EPS_W-1:0]        cfg_wdata,
  input  logic signed [31:0]               in_r0c0,
  input  logic signed [31:0]               in_r0c1,
  input  logic signed [31:0]               in_r0c2,
  input  logic signed [31:0]               in_r1c0,
  input  logic signed [31:0]               in_r1c1,
  input  logic signed [31:0]               in_r1c2,
  input  logic signed [31:0]               in_r2c0,
  input  logic signed [31:0]               in_r2c1,
  input  logic signed [31:0]               in_r2c2,
  output logic                             done,
  output logic signed [31:0]               inv_r0c0,
  output logic signed [31:0]               inv_r0c1,
  output logic signed [31:0]               inv_r0c2,
  output logic signed [31:0]               inv_r1c0,
  output logic signed [31:0]               inv_r1c1,
  output logic signed [31:0]               inv_r1c2,
  output logic signed [31:0]               inv_r2c0,
  output logic signed [31:0]               inv_r2c1,
  output logic signed [31:0]               inv_r2c2,
  output logic                             invertible
);

  localparam int NE  = mi3_pkg::N_ELEM;
  localparam int DW  = mi3_pkg::DMAG_W;
  localparam int LAT = 8 + mi3_pkg::DIV_LAT;

  logic [mi3_pkg::EPS_W-1:0] det_epsilon;
  logic [LAT-1:0]            valid;

  mi3_pkg::elem_t e_in [NE];
  mi3_pkg::elem_t e1   [NE];
  mi3_pkg::prod_t p_ab [NE];
  mi3_pkg::prod_t p_cd [NE];
  mi3_pkg::elem_t e2   [3];
  mi3_pkg::cof_t  cof3 [NE];
  mi3_pkg::elem_t e3   [3];
  mi3_pkg::cof_t  cof4 [NE];
  logic signed [63:0] pp_hi [3];
  logic signed [64:0] pp_lo [3];
  mi3_pkg::cof_t  cof5 [NE];
  logic signed [mi3_pkg::DPP_W-1:0] dp5 [3];
  mi3_pkg::cof_t  cof6 [NE];
  mi3_pkg::det_t  det6;

  logic [DW-1:0]  dmag7;
  logic           sing7;
  logic [mi3_pkg::COF_W-1:0] cmag7 [NE];
  logic           neg7 [NE];

  logic [mi3_pkg::DIV_LAT-1:0] sing_pipe;
  logic [mi3_pkg::QUO_W-1:0]   div_res [NE];
  logic [mi3_pkg::QUO_W-1:0]   inv_out [NE];

  assign busy = 1'b0;

  assign e_in[0] = in_r0c0;
  assign e_in[1] = in_r0c1;
  assign e_in[2] = in_r0c2;
  assign e_in[3] = in_r1c0;
  assign e_in[4] = in_r1c1;
  assign e_in[5] = in_r1c2;
  assign e_in[6] = in_r2c0;
  assign e_in[7] = in_r2c1;
  assign e_in[8] = in_r2c2;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= mi3_pkg::EPS_W'(1);
    end else if (cfg_we) begin
      det_epsilon <= cfg_wdata;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[LAT-2:0], start & ~busy};
    end
  end

  assign done = valid[LAT-1];

  // stage 1: capture word, stage 2: element products
  always_ff @(posedge clk) begin
    e1 <= e_in;
    for (int k = 0; k < NE; k++) begin
      p_ab[k] <= e1[mi3_pkg::COF_A[k]] * e1[mi3_pkg::COF_B[k]];
      p_cd[k] <= e1[mi3_pkg::COF_C[k]] * e1[mi3_pkg::COF_D[k]];
    end
    for (int j = 0; j < 3; j++) begin
      e2[j] <= e1[j];
    end
  end

  // stage 3: cofactors
  always_ff @(posedge clk) begin
    for (int k = 0; k < NE; k++) begin
      cof3[k] <= p_ab[k] - p_cd[k];
    end
    e3 <= e2;
  end

  // stage 4: first-row element times cofactor, split in 32-bit halves
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pp_hi[j] <= e3[j] * $signed(cof3[3*j][63:32]);
      pp_lo[j] <= e3[j] * $signed({1'b0, cof3[3*j][31:0]});
    end
    cof4 <= cof3;
  end

  // stage 5: recombine partial products
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dp5[j] <= $signed({pp_hi[j], 32'h0}) + mi3_pkg::DPP_W'(pp_lo[j]);
    end
    cof5 <= cof4;
  end

  // stage 6: determinant
  always_ff @(posedge clk) begin
    det6 <= mi3_pkg::DET_W'(dp5[0]) + mi3_pkg::DET_W'(dp5[1]) + mi3_pkg::DET_W'(dp5[2]);
    cof6 <= cof5;
  end

  // stage 7: magnitudes, signs and singularity test
  always_ff @(posedge clk) begin
    logic [mi3_pkg::DET_W-1:0] dabs;
    logic [DW-1:0]             thr;
    logic                      dneg;
    dneg  = det6[mi3_pkg::DET_W-1];
    dabs  = dneg ? ('0 - det6) : det6;
    thr   = DW'(det_epsilon) << (2 * FRAC_BITS);
    dmag7 <= dabs[DW-1:0];
    sing7 <= (dabs[DW-1:0] == '0) || (dabs[DW-1:0] < thr);
    for (int k = 0; k < NE; k++) begin
      cmag7[k] <= cof6[k][mi3_pkg::COF_W-1] ? ('0 - cof6[k]) : cof6[k];
      neg7[k]  <= cof6[k][mi3_pkg::COF_W-1] ^ dneg;
    end
  end

  // singular flag follows the divider depth
  always_ff @(posedge clk) begin
    sing_pipe <= {sing_pipe[mi3_pkg::DIV_LAT-2:0], sing7};
  end

  // nine divider lanes
  for (genvar k = 0; k < NE; k++) begin : g_div
    mi3_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .num_mag (cmag7[k]),
      .num_neg (neg7[k]),
      .den     (dmag7),
      .quo     (div_res[k])
    );
  end

  // output word
  always_ff @(posedge clk) begin
    for (int k = 0; k < NE; k++) begin
      inv_out[k] <= sing_pipe[mi3_pkg::DIV_LAT-1] ? '0 : div_res[k];
    end
    invertible <= ~sing_pipe[mi3_pkg::DIV_LAT-1];
  end

  assign inv_r0c0 = inv_out[0];
  assign inv_r0c1 = inv_out[1];
  assign inv_r0c2 = inv_out[2];
  assign inv_r1c0 = inv_out[3];
  assign inv_r1c1 = inv_out[4];
  assign inv_r1c2 = inv_out[5];
  assign inv_r2c0 = inv_out[6];
  assign inv_r2c1 = inv_out[7];
  assign inv_r2c2 = inv_out[8];

  // a done word always traces back to an earlier start at the head of the valid pipeline
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("done without matching start");

  // a singular word carries all-zero elements
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !invertible) |-> (inv_r0c0 == 0 && inv_r0c1 == 0 && inv_r0c2 == 0 &&
                              inv_r1c0 == 0 && inv_r1c1 == 0 && inv_r1c2 == 0 &&
                              inv_r2c0 == 0 && inv_r2c1 == 0 && inv_r2c2 == 0))
    else $error("singular word with nonzero elements");

  // a divisor handed to the lanes as invertible is never zero
  a_no_zero_divide: assert property (@(posedge clk) disable iff (rst)
    (valid[6] && !sing7) |-> (dmag7 != '0))
    else $error("zero determinant passed as invertible");

endmodule

### test/tb_matrix3x3_inverse.sv
// testbench for the 3x3 fixed-point matrix inverse: directed table, then random matrices
`timescale 1ns / 100ps

module tb_matrix3x3_inverse;

  localparam int FRAC       = 16;
  localparam int PHASE_LEN  = 190;
  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN_WAIT = 60;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] EMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] EMIN = 32'h8000_0000;

  typedef logic [8:0][31:0] mat_t;
  typedef struct packed {
    mat_t e;
    logic ok;
  } inv_word_t;
  typedef struct packed {
    mat_t      m;
    logic      chk;
    inv_word_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [mi3_pkg::EPS_W-1:0] cfg_wdata = '0;
  logic signed [31:0] in_r0c0 = '0, in_r0c1 = '0, in_r0c2 = '0;
  logic signed [31:0] in_r1c0 = '0, in_r1c1 = '0, in_r1c2 = '0;
  logic signed [31:0] in_r2c0 = '0, in_r2c1 = '0, in_r2c2 = '0;
  logic done, invertible;
  logic signed [31:0] inv_r0c0, inv_r0c1, inv_r0c2;
  logic signed [31:0] inv_r1c0, inv_r1c1, inv_r1c2;
  logic signed [31:0] inv_r2c0, inv_r2c1, inv_r2c2;

  inv_word_t   inverse_q[$];
  logic [30:0] eps_model = 31'd1;
  int          errors = 0;
  int          idle_cycles = 0;
  logic        accepted_now = 1'b0;
  logic        allow_gaps = 1'b1;
  dir_row_t    dir_rows[$];

  always #6 clk = ~clk;

  matrix3x3_inverse #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_r0c0(in_r0c0), .in_r0c1(in_r0c1), .in_r0c2(in_r0c2),
    .in_r1c0(in_r1c0), .in_r1c1(in_r1c1), .in_r1c2(in_r1c2),
    .in_r2c0(in_r2c0), .in_r2c1(in_r2c1), .in_r2c2(in_r2c2),
    .done(done),
    .inv_r0c0(inv_r0c0), .inv_r0c1(inv_r0c1), .inv_r0c2(inv_r0c2),
    .inv_r1c0(inv_r1c0), .inv_r1c1(inv_r1c1), .inv_r1c2(inv_r1c2),
    .inv_r2c0(inv_r2c0), .inv_r2c1(inv_r2c1), .inv_r2c2(inv_r2c2),
    .invertible(invertible)
  );

  // exact adjugate inverse, wide signed arithmetic
  function automatic inv_word_t predict_inverse(mat_t m, logic [30:0] eps);
    logic signed [127:0] x[9];
    logic signed [127:0] c[9];
    logic signed [127:0] det;
    logic [127:0] dmag, thr, cmag, q;
    inv_word_t r;
    for (int i = 0; i < 9; i++) x[i] = {{96{m[i][31]}}, m[i]};
    c[0] = x[4]*x[8] - x[7]*x[5];
    c[1] = x[2]*x[7] - x[1]*x[8];
    c[2] = x[1]*x[5] - x[2]*x[4];
    c[3] = x[5]*x[6] - x[3]*x[8];
    c[4] = x[0]*x[8] - x[2]*x[6];
    c[5] = x[3]*x[2] - x[0]*x[5];
    c[6] = x[3]*x[7] - x[6]*x[4];
    c[7] = x[6]*x[1] - x[0]*x[7];
    c[8] = x[0]*x[4] - x[3]*x[1];
    det = x[0]*c[0] + x[1]*c[3] + x[2]*c[6];
    dmag = det[127] ? -det : det;
    thr = {97'd0, eps} << (2*FRAC);
    r = '0;
    if (dmag == 0 || dmag < thr) return r;
    r.ok = 1'b1;
    for (int i = 0; i < 9; i++) begin
      cmag = c[i][127] ? -c[i] : c[i];
      q = (cmag << (2*FRAC)) / dmag;
      if (c[i][127] != det[127]) begin
        r.e[i] = (q > 128'h8000_0000) ? EMIN : 32'(-q);
      end else begin
        r.e[i] = (q > 128'h7FFF_FFFF) ? EMAX : q[31:0];
      end
    end
    return r;
  endfunction

  function automatic mat_t mk_mat(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d, logic [31:0] e, logic [31:0] f,
                                  logic [31:0] g, logic [31:0] h, logic [31:0] k);
    mat_t m;
    m[0] = a; m[1] = b; m[2] = c; m[3] = d; m[4] = e;
    m[5] = f; m[6] = g; m[7] = h; m[8] = k;
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one word onto the ports, held until taken
  task automatic send_word(mat_t m);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    in_r0c0 <= m[0]; in_r0c1 <= m[1]; in_r0c2 <= m[2];
    in_r1c0 <= m[3]; in_r1c1 <= m[4]; in_r1c2 <= m[5];
    in_r2c0 <= m[6]; in_r2c1 <= m[7]; in_r2c2 <= m[8];
    do @(posedge clk); while (busy);
    inverse_q.push_back(predict_inverse(m, eps_model));
    accepted_now = 1'b1;
  endtask

  // wait for the pipeline to empty, then write the threshold
  task automatic set_threshold(logic [30:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (inverse_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_model = v;
  endtask

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(0, 6))
      0: return EMAX;
      1: return EMIN;
      2: return 32'd0;
      3: return 32'd1;
      4: return 32'hFFFF_FFFF;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  function automatic logic [31:0] small_val();
    logic [31:0] v;
    v = $urandom_range(0, 32'h3_FFFF);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (kind < 2) m[i] = $urandom;
      else if (kind == 9) m[i] = pick_extreme();
      else m[i] = small_val();
    end
    // nearly or exactly dependent rows: third row is the sum of the others, plus a nudge for kind 7
    if (kind == 7 || kind == 8) begin
      for (int j = 0; j < 3; j++)
        m[6+j] = m[j] + m[3+j] + ((kind == 7) ? 32'($urandom_range(0, 3)) : 32'd0);
    end
    return m;
  endfunction

  task automatic load_table();
    inv_word_t z, id;
    z = '0;
    id = '0;
    id.ok = 1'b1;
    id.e = mk_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
    dir_rows.push_back('{mk_mat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
    dir_rows.push_back('{id.e, 1'b1, id});
    dir_rows.push_back('{mk_mat(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX),
                         1'b1, z});
    dir_rows.push_back('{mk_mat(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN),
                         1'b1, z});
    // tiny diagonal: determinant under the threshold
    dir_rows.push_back('{mk_mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, z});
    dir_rows.push_back('{mk_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1,
                         '{mk_mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1'b1}});
    dir_rows.push_back('{mk_mat(2*ONE, 0, 0, 0, 2*ONE, 0, 0, 0, 2*ONE), 1'b1,
                         '{mk_mat(ONE/2, 0, 0, 0, ONE/2, 0, 0, 0, ONE/2), 1'b1}});
    // determinant exactly at the threshold, quotients saturate high and low, then a permutation and extreme matrices
    dir_rows.push_back('{mk_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, 1), 1'b0, z});
    dir_rows.push_back('{mk_mat(ONE, 0, 0, 0, ONE, 0, 0, 0, -1), 1'b0, z});
    dir_rows.push_back('{mk_mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 1'b0, z});
    dir_rows.push_back('{mk_mat(EMAX, EMIN, 0, EMIN, EMAX, EMIN, 0, EMIN, EMAX), 1'b0, z});
    dir_rows.push_back('{mk_mat(EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN), 1'b0, z});
    dir_rows.push_back('{mk_mat(EMAX, 1, 0, -1, EMAX, 1, 0, -1, EMAX), 1'b0, z});
    // dependent rows: exactly singular, then a general matrix
    dir_rows.push_back('{mk_mat(3*ONE, ONE, 7, 3*ONE, ONE, 7, 5, -9, ONE), 1'b1, z});
    dir_rows.push_back('{mk_mat(3*ONE, -ONE, 2*ONE, ONE, 4*ONE, -ONE, 2, ONE, 5*ONE),
                         1'b0, z});
  endtask

  // stimulus
  initial begin
    inv_word_t p;
    load_table();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[k]) begin
      if (dir_rows[k].chk) begin
        p = predict_inverse(dir_rows[k].m, eps_model);
        if (p != dir_rows[k].want) begin
          $display("table row %0d disagrees with the predictor", k);
          errors++;
        end
      end
      send_word(dir_rows[k].m);
    end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_threshold(31'd0);
        1: set_threshold(31'h7FFF_FFFF);
        2: set_threshold(31'($urandom_range(0, 1000)));
        3: set_threshold(31'($urandom));
        default: set_threshold(31'd1);
      endcase
      if (ph == 4) allow_gaps = 1'b0;
      for (int n = 0; n < PHASE_LEN; n++) send_word(random_matrix());
    end
    start <= 1'b0;
    @(posedge clk);
    while (inverse_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result check against the oldest expected word
  always @(posedge clk) begin
    inv_word_t want;
    inv_word_t got;
    if (!rst && done) begin
      got.e = mk_mat(inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
                     inv_r2c0, inv_r2c1, inv_r2c2);
      got.ok = invertible;
      if (inverse_q.size() == 0) begin
        $display("unexpected word at %0t", $realtime);
        errors++;
      end else begin
        want = inverse_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.e[i] !== want.e[i])
            report_mismatch($sformatf("inv[%0d]", i), got.e[i], want.e[i]);
        if (got.ok !== want.ok) report_mismatch("invertible", 32'(got.ok), 32'(want.ok));
      end
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (accepted_now || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    accepted_now = 1'b0;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog timeout at %0t", $realtime);
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

### files.f
rtl/mi3_pkg.sv
rtl/mi3_div.sv
rtl/matrix3x3_inverse.sv
test/tb_matrix3x3_inverse.sv
